>>> hdl/ippe_pkg.sv
package ippe_pkg;

  localparam int PALETTE_DEPTH_DEF = 16;
  localparam int MAX_DIM_DEF       = 1024;
  localparam int BUFFER_PIXELS_DEF = 65536;

  localparam int DIM_W   = 11;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 13;
  localparam int PADDR_W = 25;

  typedef enum logic [1:0] {
    REQ_PALETTE = 2'd0,
    REQ_DATA    = 2'd1,
    REQ_START   = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    CFG_DEPTH_SELECT  = 3'd0,
    CFG_IMAGE_WIDTH   = 3'd1,
    CFG_IMAGE_HEIGHT  = 3'd2,
    CFG_ORIGIN_X      = 3'd3,
    CFG_ORIGIN_Y      = 3'd4,
    CFG_ROW_PITCH     = 3'd5,
    CFG_FLIP_ROWS     = 3'd6,
    CFG_PALETTE_COUNT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic             depth_select;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [9:0]       origin_x;
    logic [9:0]       origin_y;
    logic [DIM_W-1:0] row_pitch;
    logic             flip_rows;
    logic [4:0]       palette_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             depth4;
    logic [COL_W-1:0] col0;
    logic [ROW_W-1:0] dest_row;
  } byte_desc_t;

  typedef struct packed {
    logic        issue;
    logic        we;
    logic        last;
    logic [15:0] address;
  } pix_t;

  typedef logic [255:0][7:0] gamma_rom_t;

  localparam logic [63:0] QONE     = 64'd1 << 30;
  localparam logic [63:0] LN2_Q    = 64'd744261118;
  localparam logic [63:0] GAMMA_PQ = (64'd899993 << 30) / 64'd1100000;

  // restoring long division, elaboration time only
  function automatic logic [63:0] div_u64(input logic [63:0] dividend,
                                          input logic [63:0] divisor);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], dividend[b]};
      if (rem >= {1'b0, divisor}) begin
        rem = rem - {1'b0, divisor};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] log2_q(input logic [31:0] v);
    logic [63:0] m;
    logic [63:0] acc;
    int unsigned k;
    k = 0;
    for (int i = 0; i < 31; i++) begin
      if ((v >> (i + 1)) != 32'd0) k = i + 1;
    end
    m = ({32'd0, v} << 30) >> k;
    acc = 64'(k) << 30;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (QONE << 1)) begin
        m = m >> 1;
        acc = acc | (64'd1 << b);
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] exp_neg_q(input logic [63:0] u);
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] term;
    plus = QONE;
    minus = 64'd0;
    term = QONE;
    for (int n = 1; n <= 24; n++) begin
      term = div_u64((term * u) >> 30, 64'(n));
      if ((n % 2) == 1) minus = minus + term;
      else plus = plus + term;
    end
    return (plus > minus) ? plus - minus : 64'd0;
  endfunction

  function automatic logic [7:0] gamma_entry(input logic [7:0] v);
    logic [63:0] d;
    logic [63:0] e;
    logic [63:0] f;
    logic [63:0] pw;
    logic [63:0] num;
    logic [63:0] sub;
    logic [63:0] q;
    logic [63:0] sh;
    if (v == 8'd0) return 8'd0;
    d = (64'd8 << 30) - log2_q({24'd0, v});
    e = (d * GAMMA_PQ) >> 30;
    sh = e >> 30;
    f = e & (QONE - 64'd1);
    pw = exp_neg_q((f * LN2_Q) >> 30);
    pw = (sh < 64'd63) ? (pw >> sh) : 64'd0;
    num = pw * 64'd1055 * 64'd256;
    sub = (64'd55 * 64'd256) << 30;
    if (num <= sub) return 8'd0;
    q = div_u64(num - sub, 64'd1000 << 30);
    return (q > 64'd255) ? 8'd255 : q[7:0];
  endfunction

  function automatic gamma_rom_t gamma_rom_init();
    gamma_rom_t rom;
    for (int v = 0; v < 256; v++) begin
      rom[v] = gamma_entry(8'(v));
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = gamma_rom_init();

endpackage

>>> hdl/ippe_ram.sv
module ippe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read and a write at the same edge return the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ippe_scan_ctrl.sv
module ippe_scan_ctrl #(
  parameter int MAX_DIM = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ippe_pkg::cfg_t      cfg,
  input  logic                data_acc,
  input  logic                start_acc,
  input  logic [7:0]          data_byte,
  output logic                load,
  output ippe_pkg::byte_desc_t desc
);
  import ippe_pkg::*;

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic             done_r, done_nxt;

  logic [DIM_W-1:0] wid, hgt;
  logic [DIM_W:0]   row_bytes, col_inc;
  logic             active;

  always_comb begin
    wid = (32'(cfg.image_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_width;
    hgt = (32'(cfg.image_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_height;
    row_bytes = (DIM_W+1)'(1) + (cfg.depth_select ? (((DIM_W+1)'(wid) + 1'b1) >> 1)
                                                  : (((DIM_W+1)'(wid) + 2'd3) >> 2));
    col_inc = (DIM_W+1)'(col_r) + 1'b1;
    active = !done_r && (row_r < hgt);

    col_nxt = col_r;
    row_nxt = row_r;
    done_nxt = done_r;
    if (start_acc) begin
      col_nxt = '0;
      row_nxt = '0;
      done_nxt = 1'b0;
    end else if (data_acc) begin
      if (!active) begin
        done_nxt = 1'b1;
      end else if (col_inc >= row_bytes) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
        if ((DIM_W+1)'(row_r) + 1'b1 >= (DIM_W+1)'(hgt)) done_nxt = 1'b1;
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end

    load = data_acc && active && (col_r != '0);
    desc.data = data_byte;
    desc.depth4 = cfg.depth_select;
    desc.col0 = cfg.depth_select ? ((COL_W'(col_r) - 1'b1) << 1)
                                 : ((COL_W'(col_r) - 1'b1) << 2);
    desc.dest_row = cfg.flip_rows
                  ? ROW_W'(cfg.origin_y) + ROW_W'(hgt) - 1'b1 - ROW_W'(row_r)
                  : ROW_W'(cfg.origin_y) + ROW_W'(row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      done_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

>>> hdl/ippe_expander.sv
module ippe_expander #(
  parameter int PALETTE_DEPTH = 16,
  parameter int MAX_DIM       = 1024,
  parameter int BUFFER_PIXELS = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ippe_pkg::cfg_t                   cfg,
  input  logic                             load,
  input  ippe_pkg::byte_desc_t             desc,
  input  logic                             adv,
  output logic                             ready,
  output logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
  output ippe_pkg::pix_t                   pix
);
  import ippe_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  logic             busy_r, busy_nxt;
  logic [1:0]       j_r, j_nxt;
  byte_desc_t       desc_r;

  logic [7:0]         sh;
  logic [3:0]         code;
  logic               last;
  logic [COL_W-1:0]   col;
  logic [PADDR_W-1:0] full_addr;
  logic [4:0]         limit;
  logic [DIM_W-1:0]   wid;
  logic               we;

  always_comb begin
    limit = (32'(cfg.palette_count) > 32'(PALETTE_DEPTH)) ? 5'(PALETTE_DEPTH)
                                                          : cfg.palette_count;
    wid = (32'(cfg.image_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_width;
    sh = desc_r.depth4 ? (desc_r.data << {j_r[0], 2'b00}) : (desc_r.data << {j_r, 1'b0});
    code = desc_r.depth4 ? sh[7:4] : {2'b00, sh[7:6]};
    last = desc_r.depth4 ? j_r[0] : (j_r == 2'd3);
    col = desc_r.col0 + COL_W'(j_r);
    full_addr = PADDR_W'(desc_r.dest_row) * PADDR_W'(cfg.row_pitch)
              + PADDR_W'(cfg.origin_x) + PADDR_W'(col);
    we = (code != 4'd0) && (5'(code) < limit) && (col < COL_W'(wid))
      && (full_addr < PADDR_W'(BUFFER_PIXELS));

    pix.issue = busy_r && adv;
    pix.we = we;
    pix.last = last;
    pix.address = we ? full_addr[15:0] : 16'd0;
    rd_addr = code[PAL_AW-1:0];
    ready = !busy_r || (pix.issue && last);

    busy_nxt = busy_r;
    j_nxt = j_r;
    if (load) begin
      busy_nxt = 1'b1;
      j_nxt = 2'd0;
    end else if (pix.issue) begin
      if (last) busy_nxt = 1'b0;
      else j_nxt = j_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      j_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      j_r <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc;
    end
  end

endmodule

>>> hdl/indexed_pixel_palette_expander.sv
// Channel  Direction  Handshake               Payload
// in       slave      in_tvalid / in_tready   tuser: req_type; tdata: palette or data byte
// out      master     out_tvalid / out_tready tdata: address, rgb; tuser: we; tlast: last
// cfg      slave      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// One pixel per cycle through the single palette read port, unless out_tready
// holds the output: a 4-bit data byte expands to 2 pixels, a 2-bit byte to 4.
// A byte's first pixel is registered in the expander, then in the output stage.
// Reset restores register defaults and clears scan counters; palette is
// undefined until written. out_tready low holds the output and the expander;
// in_tready drops while a byte's pixels are still being issued.
module indexed_pixel_palette_expander #(
  parameter int PALETTE_DEPTH = ippe_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_DIM       = ippe_pkg::MAX_DIM_DEF,
  parameter int BUFFER_PIXELS = ippe_pkg::BUFFER_PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pal_index, raw_red, raw_green, raw_blue, data_byte, pad
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pixel_address, red, green, blue
  output logic        out_tuser,  // write_enable
  output logic        out_tlast,  // last_pixel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import ippe_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  cfg_t cfg_r, cfg_nxt;

  logic       in_acc;
  req_type_e  req;
  logic [3:0] pal_index;
  logic [7:0] raw_red, raw_green, raw_blue, data_byte;

  logic              pal_wr;
  logic [23:0]       pal_wr_data;
  logic [23:0]       pal_rd_data;
  logic [PAL_AW-1:0] pal_rd_addr;

  logic       load;
  byte_desc_t desc;
  logic       exp_ready;
  pix_t       pix;
  logic       adv;

  logic        p2_valid_r, p2_valid_nxt;
  logic        p2_we_r, p2_last_r;
  logic [15:0] p2_addr_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        CFG_DEPTH_SELECT:  cfg_nxt.depth_select = cfg_data[0];
        CFG_IMAGE_WIDTH:   cfg_nxt.image_width = cfg_data;
        CFG_IMAGE_HEIGHT:  cfg_nxt.image_height = cfg_data;
        CFG_ORIGIN_X:      cfg_nxt.origin_x = cfg_data[9:0];
        CFG_ORIGIN_Y:      cfg_nxt.origin_y = cfg_data[9:0];
        CFG_ROW_PITCH:     cfg_nxt.row_pitch = cfg_data;
        CFG_FLIP_ROWS:     cfg_nxt.flip_rows = cfg_data[0];
        CFG_PALETTE_COUNT: cfg_nxt.palette_count = cfg_data[4:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_select <= 1'b1;
      cfg_r.image_width <= 11'd320;
      cfg_r.image_height <= 11'd200;
      cfg_r.origin_x <= 10'd0;
      cfg_r.origin_y <= 10'd0;
      cfg_r.row_pitch <= 11'd320;
      cfg_r.flip_rows <= 1'b0;
      cfg_r.palette_count <= 5'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign req = req_type_e'(in_tuser);
  assign pal_index = in_tdata[3:0];
  assign raw_red = in_tdata[11:4];
  assign raw_green = in_tdata[19:12];
  assign raw_blue = in_tdata[27:20];
  assign data_byte = in_tdata[35:28];

  assign in_tready = exp_ready;
  assign in_acc = in_tvalid && in_tready;

  assign pal_wr = in_acc && (req == REQ_PALETTE) && (32'(pal_index) < 32'(PALETTE_DEPTH));
  assign pal_wr_data = {GAMMA_ROM[raw_red], GAMMA_ROM[raw_green], GAMMA_ROM[raw_blue]};

  ippe_ram #(
    .WIDTH(24),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (pal_wr),
    .wr_addr(pal_index[PAL_AW-1:0]),
    .wr_data(pal_wr_data),
    .rd_en  (pix.issue),
    .rd_addr(pal_rd_addr),
    .rd_data(pal_rd_data)
  );

  ippe_scan_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .data_acc (in_acc && (req == REQ_DATA)),
    .start_acc(in_acc && (req == REQ_START)),
    .data_byte(data_byte),
    .load     (load),
    .desc     (desc)
  );

  assign adv = !p2_valid_r || out_tready;

  ippe_expander #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .MAX_DIM      (MAX_DIM),
    .BUFFER_PIXELS(BUFFER_PIXELS)
  ) u_expander (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .load   (load),
    .desc   (desc),
    .adv    (adv),
    .ready  (exp_ready),
    .rd_addr(pal_rd_addr),
    .pix    (pix)
  );

  always_comb begin
    p2_valid_nxt = p2_valid_r;
    if (adv) p2_valid_nxt = pix.issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else begin
      p2_valid_r <= p2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.issue) begin
      p2_we_r <= pix.we;
      p2_last_r <= pix.last;
      p2_addr_r <= pix.address;
    end
  end

  assign out_tvalid = p2_valid_r;
  assign out_tdata = {(p2_we_r ? pal_rd_data[7:0] : 8'd0),
                      (p2_we_r ? pal_rd_data[15:8] : 8'd0),
                      (p2_we_r ? pal_rd_data[23:16] : 8'd0),
                      p2_addr_r};
  assign out_tuser = p2_we_r;
  assign out_tlast = p2_last_r;

  a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> exp_ready)
    else $error("byte loaded while expander still busy");

  a_issue_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    pix.issue |-> (!p2_valid_r || out_tready))
    else $error("pixel issued into a full output stage");

  a_masked_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 40'd0))
    else $error("suppressed pixel carries nonzero payload");

  a_pal_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pal_wr |=> !(p2_valid_r && $past(pix.issue) && !$past(pix.last)))
    else $error("palette written while a byte was mid-expansion");

endmodule
